// ===== rtl/clipped_rectangle_span_generator_unit_assert.svh =====
// Assertion macros shared by the span generator RTL.
`ifndef CLIPPED_RECTANGLE_SPAN_GENERATOR_UNIT_ASSERT_SVH
`define CLIPPED_RECTANGLE_SPAN_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CRSG_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRSG_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/crsg_pkg.sv =====
// Package: shared types and constants of the span generator.
`default_nettype none
package crsg_pkg;

   localparam int CORNER_W = 16;
   localparam int COLOUR_W = 8;
   localparam int CFG_W    = 13;
   localparam int LEN_W    = 13;
   localparam int ADDR_W   = 24;
   localparam int CSR_IDX_W = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_NEXT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_PITCH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd2;

   localparam logic [CFG_W-1:0] LINE_PITCH_RESET    = 13'd640;
   localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = 13'd480;

   typedef struct packed {
      logic                span_valid;
      logic                span_last;
      logic [COLOUR_W-1:0] span_colour;
      logic [LEN_W-1:0]    span_length;
   } span_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/crsg_req_if.sv =====
// Interface: request channel carrying load and next-span items.
`default_nettype none
interface crsg_req_if;
   logic                                valid;
   logic                                ready;
   logic                                operation;
   logic signed [crsg_pkg::CORNER_W-1:0] corner_x0;
   logic signed [crsg_pkg::CORNER_W-1:0] corner_y0;
   logic signed [crsg_pkg::CORNER_W-1:0] corner_x1;
   logic signed [crsg_pkg::CORNER_W-1:0] corner_y1;
   logic [crsg_pkg::COLOUR_W-1:0]       colour_index;
   logic                                fill_mode;

   modport source (output valid, operation, corner_x0, corner_y0, corner_x1, corner_y1,
                   colour_index, fill_mode, input ready);
   modport sink   (input valid, operation, corner_x0, corner_y0, corner_x1, corner_y1,
                   colour_index, fill_mode, output ready);
endinterface
`default_nettype wire

// ===== rtl/crsg_rsp_if.sv =====
// Interface: response channel carrying one span result per request item.
`default_nettype none
interface crsg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          span_valid;
   logic [crsg_pkg::ADDR_W-1:0]   span_address;
   logic [crsg_pkg::LEN_W-1:0]    span_length;
   logic [crsg_pkg::COLOUR_W-1:0] span_colour;
   logic                          span_last;

   modport source (output valid, span_valid, span_address, span_length, span_colour,
                   span_last, input ready);
   modport sink   (input valid, span_valid, span_address, span_length, span_colour,
                   span_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/crsg_front.sv =====
// Front end: clips loads, walks the rectangle and emits one span entry per item.
`default_nettype none
`include "clipped_rectangle_span_generator_unit_assert.svh"
module crsg_front #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   crsg_req_if.sink                        req,
   input  wire logic [crsg_pkg::CFG_W-1:0] screen_width,
   input  wire logic [crsg_pkg::CFG_W-1:0] screen_height,
   output logic                            push_valid,
   input  wire logic                       push_ready,
   output crsg_pkg::span_ctl_type          push_ctl,
   output logic [COORD_BITS-1:0]           push_col,
   output logic [COORD_BITS-1:0]           push_row
);

   localparam int CW    = COORD_BITS;
   localparam int DIM_W = CW + 1;
   localparam int CMP_W = ((DIM_W > crsg_pkg::CORNER_W) ? DIM_W : crsg_pkg::CORNER_W) + 1;
   localparam int LW    = (DIM_W > crsg_pkg::LEN_W) ? DIM_W : crsg_pkg::LEN_W;
   localparam int DIM_LIM = 1 << CW;

   typedef enum logic [1:0] {
      PHASE_TOP,
      PHASE_BOTTOM,
      PHASE_LEFT,
      PHASE_RIGHT
   } phase_type;

   logic [CW-1:0]                 left_ff, left_in, right_ff, right_in;
   logic [CW-1:0]                 top_ff, top_in, bottom_ff, bottom_in;
   logic [CW-1:0]                 cur_row_ff, cur_row_in;
   phase_type                     phase_ff, phase_in;
   logic [crsg_pkg::COLOUR_W-1:0] colour_ff, colour_in;
   logic                          fill_ff, fill_in;
   logic                          busy_ff, busy_in;

   logic                          accept;
   logic [CMP_W-1:0]              w_eff, h_eff;
   logic signed [CMP_W-1:0]       w_s, h_s, x0_s, y0_s, x1_s, y1_s;
   logic signed [CMP_W-1:0]       x_c, y_c, x2_c, y2_c;
   logic signed [CMP_W-1:0]       lo_x, hi_x, lo_y, hi_y;
   logic                          load_empty;
   logic [LW-1:0]                 full_len_wide;
   logic [crsg_pkg::LEN_W-1:0]    full_len;

   assign accept     = req.valid && push_ready;
   assign req.ready  = push_ready;
   assign push_valid = req.valid;

   // Zero dimension acts as one, oversized dimension is capped at the coordinate range.
   always_comb begin
      w_eff = CMP_W'(screen_width);
      if (screen_width == '0) begin
         w_eff = CMP_W'(1);
      end else if (CMP_W'(screen_width) > CMP_W'(DIM_LIM)) begin
         w_eff = CMP_W'(DIM_LIM);
      end
      h_eff = CMP_W'(screen_height);
      if (screen_height == '0) begin
         h_eff = CMP_W'(1);
      end else if (CMP_W'(screen_height) > CMP_W'(DIM_LIM)) begin
         h_eff = CMP_W'(DIM_LIM);
      end
   end

   assign w_s  = signed'(w_eff);
   assign h_s  = signed'(h_eff);
   assign x0_s = CMP_W'(req.corner_x0);
   assign y0_s = CMP_W'(req.corner_y0);
   assign x1_s = CMP_W'(req.corner_x1);
   assign y1_s = CMP_W'(req.corner_y1);

   // Clip both corners.
   assign x_c  = (x0_s < 0) ? '0 : ((x0_s >= w_s) ? (w_s - CMP_W'(1)) : x0_s);
   assign y_c  = (y0_s < 0) ? '0 : ((y0_s >= h_s) ? (h_s - CMP_W'(1)) : y0_s);
   assign x2_c = (x1_s >= w_s) ? (w_s - CMP_W'(1)) : x1_s;
   assign y2_c = (y1_s >= h_s) ? (h_s - CMP_W'(1)) : y1_s;

   // Outline orders the corners; a fill keeps them as clipped.
   assign lo_x = (!req.fill_mode && (x_c > x2_c)) ? x2_c : x_c;
   assign hi_x = (!req.fill_mode && (x_c > x2_c)) ? x_c  : x2_c;
   assign lo_y = (!req.fill_mode && (y_c > y2_c)) ? y2_c : y_c;
   assign hi_y = (!req.fill_mode && (y_c > y2_c)) ? y_c  : y2_c;

   assign load_empty = (req.fill_mode && (y0_s >= h_s)) || (x1_s < 0) || (y1_s < 0) ||
                       (req.fill_mode && ((x_c > x2_c) || (y_c > y2_c)));

   assign full_len_wide = LW'(right_ff) - LW'(left_ff) + LW'(1);
   assign full_len      = full_len_wide[crsg_pkg::LEN_W-1:0];

   always_comb begin
      left_in    = left_ff;
      right_in   = right_ff;
      top_in     = top_ff;
      bottom_in  = bottom_ff;
      cur_row_in = cur_row_ff;
      phase_in   = phase_ff;
      colour_in  = colour_ff;
      fill_in    = fill_ff;
      busy_in    = busy_ff;
      push_ctl   = '0;
      push_col   = '0;
      push_row   = '0;

      if (accept) begin
         if (req.operation == crsg_pkg::OP_LOAD) begin
            busy_in  = 1'b0;
            phase_in = PHASE_TOP;
            if (!load_empty) begin
               left_in    = lo_x[CW-1:0];
               right_in   = hi_x[CW-1:0];
               top_in     = lo_y[CW-1:0];
               bottom_in  = hi_y[CW-1:0];
               cur_row_in = lo_y[CW-1:0];
               colour_in  = req.colour_index;
               fill_in    = req.fill_mode;
               busy_in    = 1'b1;
            end
         end else if (busy_ff) begin
            push_ctl.span_valid  = 1'b1;
            push_ctl.span_colour = colour_ff;
            push_col             = left_ff;
            push_row             = cur_row_ff;
            push_ctl.span_length = crsg_pkg::LEN_W'(1);
            if (fill_ff) begin
               push_ctl.span_length = full_len;
               if (cur_row_ff == bottom_ff) begin
                  push_ctl.span_last = 1'b1;
               end else begin
                  cur_row_in = cur_row_ff + CW'(1);
               end
            end else begin
               unique case (phase_ff)
                  PHASE_TOP: begin
                     push_row             = top_ff;
                     push_ctl.span_length = full_len;
                     phase_in             = PHASE_BOTTOM;
                  end
                  PHASE_BOTTOM: begin
                     push_row             = bottom_ff;
                     push_ctl.span_length = full_len;
                     phase_in             = PHASE_LEFT;
                     cur_row_in           = top_ff;
                  end
                  PHASE_LEFT: begin
                     phase_in = PHASE_RIGHT;
                  end
                  PHASE_RIGHT: begin
                     push_col = right_ff;
                     if (cur_row_ff == bottom_ff) begin
                        push_ctl.span_last = 1'b1;
                     end else begin
                        cur_row_in = cur_row_ff + CW'(1);
                        phase_in   = PHASE_LEFT;
                     end
                  end
               endcase
            end
            if (push_ctl.span_last) begin
               busy_in  = 1'b0;
               phase_in = PHASE_TOP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= '0;
         right_ff   <= '0;
         top_ff     <= '0;
         bottom_ff  <= '0;
         cur_row_ff <= '0;
         phase_ff   <= PHASE_TOP;
         colour_ff  <= '0;
         fill_ff    <= 1'b0;
         busy_ff    <= 1'b0;
      end else begin
         left_ff    <= left_in;
         right_ff   <= right_in;
         top_ff     <= top_in;
         bottom_ff  <= bottom_in;
         cur_row_ff <= cur_row_in;
         phase_ff   <= phase_in;
         colour_ff  <= colour_in;
         fill_ff    <= fill_in;
         busy_ff    <= busy_in;
      end
   end

   `CRSG_ASSERT_NOW(a_bounds_ordered, clock, reset, busy_ff,
      (left_ff <= right_ff) && (top_ff <= bottom_ff), "latched rectangle out of order")
   `CRSG_ASSERT_NOW(a_row_in_range, clock, reset, busy_ff,
      (cur_row_ff >= top_ff) && (cur_row_ff <= bottom_ff), "row walker left the rectangle")
   `CRSG_ASSERT_NEXT(a_last_ends_walk, clock, reset, accept && push_ctl.span_last,
      !busy_ff, "rectangle still pending after its last span")
   `CRSG_ASSERT_NOW(a_idle_phase, clock, reset, !busy_ff,
      phase_ff == PHASE_TOP, "idle walker not parked on the top edge")

endmodule
`default_nettype wire

// ===== rtl/crsg_queue.sv =====
// Queue: short register FIFO between the front end and the address stage.
`default_nettype none
`include "clipped_rectangle_span_generator_unit_assert.svh"
module crsg_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [DATA_W-1:0] in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [DATA_W-1:0]      out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   `CRSG_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_W'(DEPTH), "queue count above depth")
   `CRSG_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop,
      count_ff == $past(count_ff) + CNT_W'(1), "push did not grow the queue")
   `CRSG_ASSERT_NEXT(a_pop_shrinks, clock, reset, pop && !push,
      count_ff == $past(count_ff) - CNT_W'(1), "pop did not shrink the queue")

endmodule
`default_nettype wire

// ===== rtl/crsg_back.sv =====
// Back end: forms the byte address of each span in two registered stages.
`default_nettype none
module crsg_back #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       pop_valid,
   output logic                            pop_ready,
   input  wire crsg_pkg::span_ctl_type     pop_ctl,
   input  wire logic [COORD_BITS-1:0]      pop_col,
   input  wire logic [COORD_BITS-1:0]      pop_row,
   input  wire logic [crsg_pkg::CFG_W-1:0] line_pitch,
   crsg_rsp_if.source                      rsp
);

   localparam int CW     = COORD_BITS;
   localparam int PROD_W = CW + crsg_pkg::CFG_W;
   localparam int SUM_W  = ((PROD_W + 1) > crsg_pkg::ADDR_W) ? (PROD_W + 1) : crsg_pkg::ADDR_W;

   logic                        s1_valid_ff, s1_valid_in;
   crsg_pkg::span_ctl_type      s1_ctl_ff;
   logic [CW-1:0]               s1_col_ff;
   logic [PROD_W-1:0]           s1_prod_ff, s1_prod_in;
   logic                        out_valid_ff, out_valid_in;
   crsg_pkg::span_ctl_type      out_ctl_ff;
   logic [crsg_pkg::ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic [SUM_W-1:0]            addr_sum;
   logic                        out_take, s1_move;

   // Output register takes a new span when empty or when its span is being taken.
   assign out_take  = !out_valid_ff || rsp.ready;
   assign s1_move   = s1_valid_ff && out_take;
   assign pop_ready = !s1_valid_ff || out_take;

   assign s1_prod_in   = PROD_W'(pop_row) * PROD_W'(line_pitch);
   assign s1_valid_in  = pop_valid || (s1_valid_ff && !out_take);
   assign addr_sum     = SUM_W'(s1_prod_ff) + SUM_W'(s1_col_ff);
   assign out_addr_in  = addr_sum[crsg_pkg::ADDR_W-1:0];
   assign out_valid_in = s1_valid_ff || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop_ready) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (out_take) begin
            out_valid_ff <= out_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         s1_ctl_ff  <= pop_ctl;
         s1_col_ff  <= pop_col;
         s1_prod_ff <= s1_prod_in;
      end
      if (s1_move) begin
         out_ctl_ff  <= s1_ctl_ff;
         out_addr_ff <= out_addr_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.span_valid   = out_ctl_ff.span_valid;
   assign rsp.span_address = out_addr_ff;
   assign rsp.span_length  = out_ctl_ff.span_length;
   assign rsp.span_colour  = out_ctl_ff.span_colour;
   assign rsp.span_last    = out_ctl_ff.span_last;

endmodule
`default_nettype wire

// ===== rtl/clipped_rectangle_span_generator_unit.sv =====
// Top level: clipped rectangle span generator with its configuration registers.
//
// Usage: a transfer on req_chan with operation 0 loads a rectangle (corners are
// clipped to screen_width x screen_height and latched with colour and mode); a
// transfer with operation 1 asks for the next span. Every request transfer gives
// exactly one rsp_chan transfer: a load, or a request with no rectangle pending,
// answers span_valid 0 with all other fields zero; otherwise the span carries
// address col + row * line_pitch (24-bit wrap), length, colour and span_last on
// the final span of the rectangle.
// Throughput: one item per cycle while rsp_chan does not stall. A result is
// registered in the queue slot, the multiply stage and the output register in turn.
// The walker state advances in the front end at the transfer itself, so the
// loop through it sets the rate.
// Reset clears the walker, the queue and the output stage and loads pitch 640,
// width 640, height 480. Write csr_* only while no result is outstanding.
// When rsp_chan stalls, results hold in the output register, the multiply stage
// fills, then the two-entry queue; req_chan.ready drops once the queue is full.
`default_nettype none
module clipped_rectangle_span_generator_unit #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   crsg_req_if.sink                            req_chan,
   crsg_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_write_enable,
   input  wire logic [crsg_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [crsg_pkg::CFG_W-1:0]     csr_write_data
);

   localparam int ENTRY_W = $bits(crsg_pkg::span_ctl_type) + 2 * COORD_BITS;

   logic [crsg_pkg::CFG_W-1:0] line_pitch_ff, line_pitch_in;
   logic [crsg_pkg::CFG_W-1:0] screen_width_ff, screen_width_in;
   logic [crsg_pkg::CFG_W-1:0] screen_height_ff, screen_height_in;

   logic                       push_valid, push_ready;
   crsg_pkg::span_ctl_type     push_ctl;
   logic [COORD_BITS-1:0]      push_col, push_row;
   logic                       pop_valid, pop_ready;
   logic [ENTRY_W-1:0]         pop_data;
   crsg_pkg::span_ctl_type     pop_ctl;
   logic [COORD_BITS-1:0]      pop_col, pop_row;

   // Register writes; an index beyond the list is dropped.
   always_comb begin
      line_pitch_in    = line_pitch_ff;
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            crsg_pkg::CSR_LINE_PITCH:    line_pitch_in    = csr_write_data;
            crsg_pkg::CSR_SCREEN_WIDTH:  screen_width_in  = csr_write_data;
            crsg_pkg::CSR_SCREEN_HEIGHT: screen_height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pitch_ff    <= crsg_pkg::LINE_PITCH_RESET;
         screen_width_ff  <= crsg_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= crsg_pkg::SCREEN_HEIGHT_RESET;
      end else begin
         line_pitch_ff    <= line_pitch_in;
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   // Front end: clip loads, walk the rectangle, produce one entry per transfer.
   crsg_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req           (req_chan),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_ctl      (push_ctl),
      .push_col      (push_col),
      .push_row      (push_row)
   );

   // Queue decouples the walker from the address stage.
   crsg_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (crsg_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   ({push_ctl, push_col, push_row}),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   assign {pop_ctl, pop_col, pop_row} = pop_data;

   // Back end: multiply row by pitch, add column, hold the result for the sink.
   crsg_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_ctl    (pop_ctl),
      .pop_col    (pop_col),
      .pop_row    (pop_row),
      .line_pitch (line_pitch_ff),
      .rsp        (rsp_chan)
   );

endmodule
`default_nettype wire
